FILE: src/sli_pkg.sv
// shared types and constants for the name list intersection block
// no dependencies; imported by every module of the block

package sli_pkg;

  localparam int CHAR_W          = 8;
  localparam int CMD_W           = 2;
  localparam int MATCH_IDX_W     = 4;
  localparam int MAX_RESULTS     = 16;
  localparam int RES_W           = $clog2(MAX_RESULTS + 1);
  localparam int DEF_LIST_DEPTH  = 16;
  localparam int DEF_NAME_LEN    = 64;

  localparam logic [CHAR_W-1:0] CHAR_NUL = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_LOAD_A  = 2'd1,
    CMD_LOAD_B  = 2'd2,
    CMD_COMPARE = 2'd3
  } cmd_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load_a;
    logic load_b;
    logic start;
    logic next_j;
    logic next_k;
    logic next_l;
    logic rd_en;
    logic match;
    logic finish;
  } sli_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic j_done;
    logic k_done;
    logic byte_ne;
    logic byte_end;
    logic pend_valid;
    logic n_last;
    logic n_full;
  } sli_stat_t;

endpackage

FILE: src/sli_store.sv
// one name store: byte memory with one write port and one registered read port
// depends on sli_pkg

module sli_store
  import sli_pkg::*;
#(
  parameter int DEPTH = DEF_LIST_DEPTH * DEF_NAME_LEN,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [CHAR_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [CHAR_W-1:0] rd_data
);

  logic [CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/sli_datapath.sv
// datapath: both name stores, list counters, walk counters and result register
// depends on sli_pkg and sli_store

module sli_datapath
  import sli_pkg::*;
#(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH,
  parameter int NAME_LEN   = DEF_NAME_LEN
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sli_cmd_t               cmd,
  output sli_stat_t              stat,
  input  logic [CHAR_W-1:0]      in_char,
  output logic [MATCH_IDX_W-1:0] res_idx,
  output logic                   res_match,
  output logic                   res_ovf,
  output logic                   res_last
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int PW = $clog2(NAME_LEN);
  localparam int AW = $clog2(LIST_DEPTH * NAME_LEN);
  localparam int JW = (CW > MATCH_IDX_W) ? CW : MATCH_IDX_W;

  localparam logic [CW-1:0]    CNT_FULL = CW'(LIST_DEPTH);
  localparam logic [PW-1:0]    POS_MAX  = PW'(NAME_LEN - 1);
  localparam logic [AW-1:0]    NL_A     = AW'(NAME_LEN);
  localparam logic [RES_W-1:0] N_LAST   = RES_W'(MAX_RESULTS - 1);
  localparam logic [RES_W-1:0] N_FULL   = RES_W'(MAX_RESULTS);

  logic [CW-1:0]          count_a_r, count_a_nxt;
  logic [CW-1:0]          count_b_r, count_b_nxt;
  logic [PW-1:0]          pos_r, pos_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [CW-1:0]          j_r, j_nxt;
  logic [CW-1:0]          k_r, k_nxt;
  logic [PW-1:0]          l_r, l_nxt;
  logic [RES_W-1:0]       n_r, n_nxt;
  logic                   pend_r, pend_nxt;
  logic [MATCH_IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [MATCH_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic                   out_match_r, out_match_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [CW-1:0]     cnt_sel;
  logic              wr;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr_a;
  logic [AW-1:0]     rd_addr_b;
  logic [CHAR_W-1:0] rd_a;
  logic [CHAR_W-1:0] rd_b;
  logic [JW-1:0]     j_ext;

  assign cnt_sel   = cmd.load_a ? count_a_r : count_b_r;
  assign wr_addr   = AW'(cnt_sel[IW-1:0]) * NL_A + AW'(pos_r);
  assign rd_addr_a = AW'(j_r[IW-1:0]) * NL_A + AW'(l_r);
  assign rd_addr_b = AW'(k_r[IW-1:0]) * NL_A + AW'(l_r);
  assign j_ext     = JW'(j_r);

  sli_store #(
    .DEPTH (LIST_DEPTH * NAME_LEN),
    .AW    (AW)
  ) u_store_a (
    .clk     (clk),
    .wr_en   (wr && cmd.load_a),
    .wr_addr (wr_addr),
    .wr_data (in_char),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr_a),
    .rd_data (rd_a)
  );

  sli_store #(
    .DEPTH (LIST_DEPTH * NAME_LEN),
    .AW    (AW)
  ) u_store_b (
    .clk     (clk),
    .wr_en   (wr && cmd.load_b),
    .wr_addr (wr_addr),
    .wr_data (in_char),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr_b),
    .rd_data (rd_b)
  );

  // list loading
  always_comb begin
    count_a_nxt = count_a_r;
    count_b_nxt = count_b_r;
    pos_nxt     = pos_r;
    ovf_nxt     = ovf_r;
    wr          = 1'b0;
    if (cmd.clear) begin
      count_a_nxt = '0;
      count_b_nxt = '0;
      pos_nxt     = '0;
      ovf_nxt     = 1'b0;
    end else if (cmd.load_a || cmd.load_b) begin
      if (cnt_sel == CNT_FULL) begin
        ovf_nxt = 1'b1;
        if (in_char == CHAR_NUL) begin
          pos_nxt = '0;
        end
      end else if (in_char == CHAR_NUL) begin
        wr      = 1'b1;
        pos_nxt = '0;
        if (cmd.load_a) begin
          count_a_nxt = count_a_r + 1'b1;
        end else begin
          count_b_nxt = count_b_r + 1'b1;
        end
      end else if (pos_r == POS_MAX) begin
        ovf_nxt = 1'b1;
      end else begin
        wr      = 1'b1;
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  // compare walk and result capture
  always_comb begin
    j_nxt         = j_r;
    k_nxt         = k_r;
    l_nxt         = l_r;
    n_nxt         = n_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    out_idx_nxt   = out_idx_r;
    out_match_nxt = out_match_r;
    out_last_nxt  = out_last_r;
    if (cmd.start) begin
      j_nxt    = '0;
      k_nxt    = '0;
      l_nxt    = '0;
      n_nxt    = '0;
      pend_nxt = 1'b0;
    end
    if (cmd.next_j) begin
      j_nxt = j_r + 1'b1;
      k_nxt = '0;
      l_nxt = '0;
    end
    if (cmd.next_k) begin
      k_nxt = k_r + 1'b1;
      l_nxt = '0;
    end
    if (cmd.next_l) begin
      l_nxt = l_r + 1'b1;
    end
    if (cmd.match) begin
      n_nxt         = n_r + 1'b1;
      pend_nxt      = 1'b1;
      pend_idx_nxt  = j_ext[MATCH_IDX_W-1:0];
      out_idx_nxt   = pend_idx_r;
      out_match_nxt = 1'b1;
      out_last_nxt  = 1'b0;
    end
    if (cmd.finish) begin
      out_idx_nxt   = pend_r ? pend_idx_r : '0;
      out_match_nxt = pend_r;
      out_last_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r <= '0;
      count_b_r <= '0;
      pos_r     <= '0;
      ovf_r     <= 1'b0;
      j_r       <= '0;
      k_r       <= '0;
      l_r       <= '0;
      n_r       <= '0;
      pend_r    <= 1'b0;
    end else begin
      count_a_r <= count_a_nxt;
      count_b_r <= count_b_nxt;
      pos_r     <= pos_nxt;
      ovf_r     <= ovf_nxt;
      j_r       <= j_nxt;
      k_r       <= k_nxt;
      l_r       <= l_nxt;
      n_r       <= n_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r  <= pend_idx_nxt;
    out_idx_r   <= out_idx_nxt;
    out_match_r <= out_match_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign stat.j_done     = (j_r == count_a_r);
  assign stat.k_done     = (k_r == count_b_r);
  assign stat.byte_ne    = (rd_a != rd_b);
  assign stat.byte_end   = (rd_a == CHAR_NUL) || (l_r == POS_MAX);
  assign stat.pend_valid = pend_r;
  assign stat.n_last     = (n_r == N_LAST);
  assign stat.n_full     = (n_r == N_FULL);

  assign res_idx   = out_idx_r;
  assign res_match = out_match_r;
  assign res_ovf   = ovf_r;
  assign res_last  = out_last_r;

endmodule

FILE: src/sli_ctrl.sv
// controller: takes commands, sequences the compare walk and result handoff
// depends on sli_pkg

module sli_ctrl
  import sli_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             out_tvalid,
  input  logic             out_tready,
  output sli_cmd_t         cmd,
  input  sli_stat_t        stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OUTER,
    S_INNER,
    S_CMP,
    S_EMIT_MID,
    S_FINISH,
    S_EMIT_END
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;
  logic   out_tvalid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          unique case (cmd_t'(in_cmd))
            CMD_CLEAR:  cmd.clear  = 1'b1;
            CMD_LOAD_A: cmd.load_a = 1'b1;
            CMD_LOAD_B: cmd.load_b = 1'b1;
            CMD_COMPARE: begin
              cmd.start = 1'b1;
              state_nxt = S_OUTER;
            end
            default: ;
          endcase
        end
      end
      S_OUTER: begin
        state_nxt = stat.j_done ? S_FINISH : S_INNER;
      end
      S_INNER: begin
        if (stat.k_done) begin
          cmd.next_j = 1'b1;
          state_nxt  = S_OUTER;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.byte_ne) begin
          cmd.next_k = 1'b1;
          state_nxt  = S_INNER;
        end else if (stat.byte_end) begin
          cmd.match = 1'b1;
          if (stat.pend_valid) begin
            state_nxt = S_EMIT_MID;
          end else if (stat.n_last) begin
            state_nxt = S_FINISH;
          end else begin
            cmd.next_j = 1'b1;
            state_nxt  = S_OUTER;
          end
        end else begin
          cmd.next_l = 1'b1;
          state_nxt  = S_INNER;
        end
      end
      S_EMIT_MID: begin
        if (out_tready) begin
          if (stat.n_full) begin
            state_nxt = S_FINISH;
          end else begin
            cmd.next_j = 1'b1;
            state_nxt  = S_OUTER;
          end
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_EMIT_END;
      end
      S_EMIT_END: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_tready_r  <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_tready_r  <= (state_nxt == S_IDLE);
      out_tvalid_r <= (state_nxt == S_EMIT_MID) || (state_nxt == S_EMIT_END);
    end
  end

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

endmodule

FILE: src/string_list_intersection.sv
// top level of the name list intersection block
// depends on sli_pkg, sli_ctrl, sli_datapath, sli_store
//
// Clear and load transactions leave in_tready high, so bytes stream in at one per
// cycle. A compare transaction holds in_tready low until its last result is taken:
// the walk reads one byte from each store per step, each store through its single
// registered read port, and each result waits for out_tready. Up to 16 results are
// given per compare, the last marked by out_tlast; a compare with no common name
// gives one transaction with out_tuser low. The stores need no clearing after reset.

module string_list_intersection
  import sli_pkg::*;
#(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH,
  parameter int NAME_LEN   = DEF_NAME_LEN
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] character
  input  logic [1:0] in_tuser,   // [1:0] command
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [3:0] match_index, [4] overflow, [7:5] zero
  output logic       out_tuser,  // [0] match_valid
  output logic       out_tlast
);

  sli_cmd_t               cmd;
  sli_stat_t              stat;
  logic [MATCH_IDX_W-1:0] res_idx;
  logic                   res_match;
  logic                   res_ovf;
  logic                   res_last;

  sli_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  sli_datapath #(
    .LIST_DEPTH (LIST_DEPTH),
    .NAME_LEN   (NAME_LEN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_char   (in_tdata),
    .res_idx   (res_idx),
    .res_match (res_match),
    .res_ovf   (res_ovf),
    .res_last  (res_last)
  );

  assign out_tdata = {3'b000, res_ovf, res_idx};
  assign out_tuser = res_match;
  assign out_tlast = res_last;

endmodule

FILE: src/sli_checker.sv
// port-level checks for the name list intersection block, bound to the top level
// depends on sli_pkg and string_list_intersection

module sli_checker
  import sli_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic [1:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // input side closed while results are offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  // a compare transaction closes the input side
  a_cmp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == CMD_COMPARE)) |=> !in_tready)
    else $error("input still ready after compare");

  // no-match result is always the final one
  a_nomatch_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tlast)
    else $error("no-match result without tlast");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast)))
    else $error("result changed while stalled");

endmodule

bind string_list_intersection sli_checker u_sli_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
